[hdl/hdlc_dfr_pkg.sv]
package hdlc_dfr_pkg;

  // Framing and escape octets.
  localparam logic [7:0] FlagByte = 8'h7E;
  localparam logic [7:0] EscByte  = 8'h7D;
  localparam logic [7:0] EscXor   = 8'h20;

  // FCS-16, reflected form.
  localparam logic [15:0] FcsInit = 16'hFFFF;
  localparam logic [15:0] FcsGood = 16'hF0B8;
  localparam logic [15:0] FcsPoly = 16'h8408;

  // Result kinds as carried on the output tuser.
  typedef enum logic [1:0] {
    KindPayload  = 2'd0,
    KindGood     = 2'd1,
    KindBadCrc   = 2'd2,
    KindOverflow = 2'd3
  } kind_e;

  // One result item.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
    logic [7:0] frame_length;
  } result_t;

  // Byte-wide FCS-16 update, eight shift steps on a 16-bit value.
  function automatic logic [15:0] fcs_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ FcsPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[hdl/hdlc_dfr_core.sv]
module hdlc_dfr_core #(
  parameter int unsigned BUF_SIZE = 128
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rx_enable_i,
  input  logic                  step_valid_i,
  input  logic [7:0]            step_byte_i,
  input  logic                  out_ready_i,
  output logic                  advance_o,
  output logic                  out_valid_o,
  output hdlc_dfr_pkg::result_t out_o
);

  localparam logic [7:0] BufLimit = BUF_SIZE[7:0];

  // Deframer state.
  logic        in_frame_q, in_frame_d;
  logic [7:0]  prev_byte_q, prev_byte_d;
  logic        esc_q, esc_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  hold0_q, hold0_d, hold1_q, hold1_d;

  // Result register.
  logic                  out_valid_q, out_valid_d;
  hdlc_dfr_pkg::result_t out_q, out_d;

  logic        do_step;
  logic        frame_start, frame_take, frame_close;
  logic        base_esc;
  logic [15:0] base_crc;
  logic [7:0]  base_count;
  logic [7:0]  unesc_byte;
  logic        got;
  logic        res_valid;
  hdlc_dfr_pkg::result_t res;

  // The stage moves on whenever the result register is free or being drained.
  assign advance_o = !out_valid_q || out_ready_i;
  assign do_step   = step_valid_i && advance_o && rx_enable_i;

  // Classify the byte against the framing state.
  assign frame_start = !in_frame_q && (prev_byte_q == hdlc_dfr_pkg::FlagByte) &&
                       (step_byte_i != hdlc_dfr_pkg::FlagByte);
  assign frame_take  = in_frame_q && (step_byte_i != hdlc_dfr_pkg::FlagByte);
  assign frame_close = in_frame_q && (step_byte_i == hdlc_dfr_pkg::FlagByte);

  // A new frame starts from cleared counters and a fresh FCS.
  assign base_esc   = frame_start ? 1'b0 : esc_q;
  assign base_crc   = frame_start ? hdlc_dfr_pkg::FcsInit : crc_q;
  assign base_count = frame_start ? 8'd0 : count_q;
  assign unesc_byte = base_esc ? (step_byte_i ^ hdlc_dfr_pkg::EscXor) : step_byte_i;
  assign got        = (base_count >= 8'd2);

  // Next state and result for one byte.
  always_comb begin
    in_frame_d  = in_frame_q;
    prev_byte_d = prev_byte_q;
    esc_d       = esc_q;
    crc_d       = crc_q;
    count_d     = count_q;
    hold0_d     = hold0_q;
    hold1_d     = hold1_q;
    res_valid   = 1'b0;
    res         = '{kind: hdlc_dfr_pkg::KindPayload, data_byte: 8'h00, frame_length: 8'h00};
    if (do_step) begin
      prev_byte_d = step_byte_i;
      if (frame_start || frame_take) begin
        if (frame_start) begin
          in_frame_d = 1'b1;
        end
        if (step_byte_i == hdlc_dfr_pkg::EscByte) begin
          esc_d   = 1'b1;
          crc_d   = base_crc;
          count_d = base_count;
        end else begin
          esc_d   = 1'b0;
          crc_d   = hdlc_dfr_pkg::fcs_update(base_crc, unesc_byte);
          hold0_d = hold1_q;
          hold1_d = unesc_byte;
          count_d = base_count + 8'd1;
        end
        if (frame_take) begin
          if (count_d >= BufLimit) begin
            // Buffer full: abort the frame and drop the held byte.
            in_frame_d = 1'b0;
            count_d    = 8'd0;
            res_valid  = 1'b1;
            res.kind   = hdlc_dfr_pkg::KindOverflow;
          end else if ((step_byte_i != hdlc_dfr_pkg::EscByte) && got) begin
            res_valid     = 1'b1;
            res.data_byte = hold0_q;
          end
        end
      end else if (frame_close) begin
        in_frame_d = 1'b0;
        count_d    = 8'd0;
        res_valid  = 1'b1;
        if ((crc_q == hdlc_dfr_pkg::FcsGood) && (count_q >= 8'd2)) begin
          res.kind         = hdlc_dfr_pkg::KindGood;
          res.frame_length = count_q - 8'd2;
        end else begin
          res.kind = hdlc_dfr_pkg::KindBadCrc;
        end
      end
    end
  end

  // Result register loads whenever the stage advances.
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (advance_o) begin
      out_valid_d = res_valid;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q  <= 1'b0;
      prev_byte_q <= hdlc_dfr_pkg::FlagByte;
      esc_q       <= 1'b0;
      crc_q       <= hdlc_dfr_pkg::FcsInit;
      count_q     <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      in_frame_q  <= in_frame_d;
      prev_byte_q <= prev_byte_d;
      esc_q       <= esc_d;
      crc_q       <= crc_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Holdback bytes and result payload need no reset.
  always_ff @(posedge clk_i) begin
    hold0_q <= hold0_d;
    hold1_q <= hold1_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

[hdl/hdlc_byte_stuffing_deframer.sv]
// HDLC byte-stuffing deframer with FCS-16 check.
// Received line bytes arrive on the s_axis stream, one byte per transfer.
// Results leave on the m_axis stream: tuser carries the kind (payload byte,
// frame good, frame bad CRC, overflow abort) and tdata the payload byte and
// the frame length. Escape bytes, flags and the two trailing FCS bytes never
// appear as payload; a bytes-in-frame count reaching BUF_SIZE aborts the frame.
// The cfg channel writes rx_enable; while it is low every byte is dropped.
// It is always ready and should be written only while the block is idle.
// An input transfer waits in the input register, then passes through the
// unescape and FCS logic into the result register. Throughput is one byte per
// cycle while the receiver does not stall, set by the single byte-wide FCS
// update between those registers.
// When the receiver stalls, the held result waits in the result register and
// one more byte waits in the input register; s_axis_tready then drops.
// Reset clears the frame state, the enable and both valid bits; the first
// frame may start with the first non-flag byte after reset.
module hdlc_byte_stuffing_deframer #(
  parameter int unsigned BUF_SIZE = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [15:8] frame_length
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i      // rx_enable
);

  logic                  rx_enable_q;
  logic                  in_valid_q;
  logic [7:0]            in_byte_q;
  logic                  advance;
  hdlc_dfr_pkg::result_t result;

  // Configuration register, always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_enable_q <= 1'b0;
    end else if (cfg_valid_i) begin
      rx_enable_q <= cfg_data_i;
    end
  end

  // Input register: refills while empty or while the downstream stage advances.
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  hdlc_dfr_core #(
    .BUF_SIZE(BUF_SIZE)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_enable_i (rx_enable_q),
    .step_valid_i(in_valid_q),
    .step_byte_i (in_byte_q),
    .out_ready_i (m_axis_tready),
    .advance_o   (advance),
    .out_valid_o (m_axis_tvalid),
    .out_o       (result)
  );

  assign m_axis_tdata = {result.frame_length, result.data_byte};
  assign m_axis_tuser = result.kind;

endmodule

[hdl/hdlc_dfr_checker.sv]
module hdlc_dfr_checker #(
  parameter int unsigned BUF_SIZE = 128
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o
);

  localparam logic [7:0] MaxLength = 8'(BUF_SIZE - 2);

  // A stalled result holds its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Only payload results carry a data byte.
  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != hdlc_dfr_pkg::KindPayload) |->
      (m_axis_tdata[7:0] == 8'h00))
    else $error("data byte set on a non-payload result");

  // Only a good frame carries a length, and it stays within the buffer.
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ((m_axis_tuser == hdlc_dfr_pkg::KindGood) && (m_axis_tdata[15:8] <= MaxLength)) ||
      ((m_axis_tuser != hdlc_dfr_pkg::KindGood) && (m_axis_tdata[15:8] == 8'h00)))
    else $error("frame length out of place or out of range");

  // The input side never stalls while the output side can move.
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("input stalled with a free result register");

  // The configuration channel never stalls.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write stalled");

endmodule

bind hdlc_byte_stuffing_deframer hdlc_dfr_checker #(
  .BUF_SIZE(BUF_SIZE)
) u_hdlc_dfr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .cfg_valid_i  (cfg_valid_i),
  .cfg_ready_o  (cfg_ready_o)
);

[test/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BufSize = 128;

  // Clock, reset and the ports of the block.
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [7:0] data_byte, [15:8] frame_length
  logic [1:0]  m_axis_tuser;           // [1:0] kind
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i    = 1'b0;   // rx_enable

  // Idle rates of both sides and the long receiver hold-off.
  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned stall_len     = 0;
  int unsigned stall_req_id  = 0;
  int unsigned stall_seen_id = 0;
  int unsigned stall_left    = 0;

  int unsigned items_sent     = 0;
  int unsigned mismatch_count = 0;

  // Results still to come out of the block, oldest first.
  hdlc_dfr_pkg::result_t expected_results[$];

  // Bytes of the next frame to be sent, before the FCS is appended.
  logic [7:0] frame_payload[$];

  // Own copy of the deframer state and its enable.
  bit          mdl_enable   = 1'b0;
  bit          mdl_in_frame = 1'b0;
  logic [7:0]  mdl_prev     = hdlc_dfr_pkg::FlagByte;
  bit          mdl_escape   = 1'b0;
  logic [15:0] mdl_crc      = hdlc_dfr_pkg::FcsInit;
  int          mdl_count    = 0;
  logic [7:0]  mdl_hold[2];

  hdlc_byte_stuffing_deframer #(
    .BUF_SIZE(BufSize)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // FCS-16 worked one bit at a time, least significant bit first.
  function automatic logic [15:0] fcs16_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    bit          fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ hdlc_dfr_pkg::FcsPoly;
      end
    end
    return c;
  endfunction

  function automatic void push_result(input hdlc_dfr_pkg::kind_e k, input logic [7:0] d,
                                      input logic [7:0] l);
    hdlc_dfr_pkg::result_t r;
    r.kind         = k;
    r.data_byte    = d;
    r.frame_length = l;
    expected_results.push_back(r);
  endfunction

  // Takes one in-frame byte; returns 1 when the oldest held byte leaves.
  function automatic bit take_unstuffed(input logic [7:0] raw, output logic [7:0] leaving);
    logic [7:0] b;
    bit         out;
    b       = raw;
    out     = 1'b0;
    leaving = 8'h00;
    if (raw == hdlc_dfr_pkg::EscByte) begin
      mdl_escape = 1'b1;
      return 1'b0;
    end
    if (mdl_escape) begin
      b          = raw ^ hdlc_dfr_pkg::EscXor;
      mdl_escape = 1'b0;
    end
    mdl_crc = fcs16_next(mdl_crc, b);
    if (mdl_count >= 2) begin
      leaving = mdl_hold[0];
      out     = 1'b1;
    end
    mdl_hold[0] = mdl_hold[1];
    mdl_hold[1] = b;
    mdl_count++;
    return out;
  endfunction

  // Works out what one accepted line byte causes at the output.
  function automatic void predict_deframe(input logic [7:0] rx);
    logic [7:0] em;
    bit         got;
    if (!mdl_enable) begin
      return;
    end
    if (!mdl_in_frame && mdl_prev == hdlc_dfr_pkg::FlagByte &&
        rx != hdlc_dfr_pkg::FlagByte) begin
      mdl_in_frame = 1'b1;
      mdl_count    = 0;
      mdl_escape   = 1'b0;
      mdl_crc      = hdlc_dfr_pkg::FcsInit;
      got          = take_unstuffed(rx, em);
    end else if (mdl_in_frame && rx != hdlc_dfr_pkg::FlagByte) begin
      got = take_unstuffed(rx, em);
      if (mdl_count + 1 > BufSize) begin
        mdl_in_frame = 1'b0;
        mdl_count    = 0;
        push_result(hdlc_dfr_pkg::KindOverflow, 8'h00, 8'h00);
      end else if (got) begin
        push_result(hdlc_dfr_pkg::KindPayload, em, 8'h00);
      end
    end else if (mdl_in_frame && rx == hdlc_dfr_pkg::FlagByte) begin
      if (mdl_crc == hdlc_dfr_pkg::FcsGood && mdl_count >= 2) begin
        push_result(hdlc_dfr_pkg::KindGood, 8'h00, 8'(mdl_count - 2));
      end else begin
        push_result(hdlc_dfr_pkg::KindBadCrc, 8'h00, 8'h00);
      end
      mdl_in_frame = 1'b0;
      mdl_count    = 0;
    end
    mdl_prev = rx;
  endfunction

  // Offers one byte, with random idle cycles in front, until it is transferred.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    predict_deframe(b);
  endtask

  // Sends a payload byte, escaped where needed and now and then where not.
  task automatic send_stuffed(input logic [7:0] b);
    logic [7:0] alt;
    alt = b ^ hdlc_dfr_pkg::EscXor;
    if (b == hdlc_dfr_pkg::FlagByte || b == hdlc_dfr_pkg::EscByte ||
        ($urandom_range(15) == 0 && alt != hdlc_dfr_pkg::FlagByte &&
         alt != hdlc_dfr_pkg::EscByte)) begin
      send_byte(hdlc_dfr_pkg::EscByte);
      send_byte(alt);
    end else begin
      send_byte(b);
    end
  endtask

  // Sends the frame held in frame_payload between flags, FCS low byte first.
  task automatic send_frame(input bit corrupt);
    logic [15:0] crc;
    logic [15:0] fcs;
    crc = hdlc_dfr_pkg::FcsInit;
    foreach (frame_payload[i]) begin
      crc = fcs16_next(crc, frame_payload[i]);
    end
    fcs = ~crc;
    if (corrupt) begin
      fcs[7:0] = fcs[7:0] ^ 8'($urandom_range(1, 255));
    end
    send_byte(hdlc_dfr_pkg::FlagByte);
    foreach (frame_payload[i]) begin
      send_stuffed(frame_payload[i]);
    end
    send_stuffed(fcs[7:0]);
    send_stuffed(fcs[15:8]);
    send_byte(hdlc_dfr_pkg::FlagByte);
  endtask

  function automatic logic [7:0] biased_byte(input int unsigned special_pct);
    if ($urandom_range(99) < special_pct) begin
      return $urandom_range(1) ? hdlc_dfr_pkg::FlagByte : hdlc_dfr_pkg::EscByte;
    end
    return 8'($urandom_range(255));
  endfunction

  // Writes rx_enable once the block has gone quiet.
  task automatic set_rx_enable(input bit v);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    mdl_enable = v;
  endtask

  task automatic random_frame();
    int unsigned n;
    frame_payload.delete();
    n = ($urandom_range(39) == 0) ? $urandom_range(124, 132) : $urandom_range(0, 12);
    repeat (n) frame_payload.push_back(biased_byte(10));
    send_frame($urandom_range(9) == 0);
  endtask

  // Ready for the receiver side: random, or held low during a requested stall.
  always @(posedge clk_i) begin
    if (stall_req_id != stall_seen_id) begin
      stall_seen_id = stall_req_id;
      stall_left    = stall_len;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Compares each result transfer with the oldest expectation.
  hdlc_dfr_pkg::result_t want;
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: kind %0d tdata %h", m_axis_tuser, m_axis_tdata);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tuser !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
          mismatch_count++;
        end
        if (m_axis_tdata[7:0] !== want.data_byte) begin
          $error("data_byte: expected %h, got %h", want.data_byte, m_axis_tdata[7:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[15:8] !== want.frame_length) begin
          $error("frame_length: expected %0d, got %0d", want.frame_length,
                 m_axis_tdata[15:8]);
          mismatch_count++;
        end
      end
    end
  end

  // While disabled nothing is taken in, the line state included.
  task automatic test_disabled_receiver();
    src_idle_pct  = 24;
    sink_idle_pct = 60;
    send_byte(hdlc_dfr_pkg::FlagByte);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(hdlc_dfr_pkg::FlagByte);
    set_rx_enable(1'b1);
  endtask

  task automatic test_directed_frames();
    // An empty payload gives an FCS of zero and a good frame of length zero.
    frame_payload.delete();
    send_frame(1'b0);
    // Extreme values and both special octets in the payload.
    frame_payload = '{8'h00, 8'hFF, hdlc_dfr_pkg::FlagByte, hdlc_dfr_pkg::EscByte};
    send_frame(1'b0);
    frame_payload = '{8'hA5};
    send_frame(1'b1);
    // A second escape keeps the mark set; one byte in the frame, so bad CRC.
    send_byte(hdlc_dfr_pkg::EscByte);
    send_byte(hdlc_dfr_pkg::EscByte);
    send_byte(8'h5E);
    send_byte(hdlc_dfr_pkg::FlagByte);
    // An escape left pending at the closing flag is cleared by the next frame start.
    send_byte(8'h31);
    send_byte(hdlc_dfr_pkg::EscByte);
    send_byte(hdlc_dfr_pkg::FlagByte);
    frame_payload.delete();
    send_frame(1'b0);
    // A single byte that happens to leave the good residue is still bad CRC.
    for (int b = 0; b < 256; b++) begin
      if (fcs16_next(hdlc_dfr_pkg::FcsInit, 8'(b)) == hdlc_dfr_pkg::FcsGood &&
          8'(b) != hdlc_dfr_pkg::EscByte && 8'(b) != hdlc_dfr_pkg::FlagByte) begin
        send_byte(8'(b));
        send_byte(hdlc_dfr_pkg::FlagByte);
      end
    end
  endtask

  // Too many bytes abort the frame; later bytes are ignored until a flag.
  task automatic test_overflow_abort();
    send_byte(hdlc_dfr_pkg::FlagByte);
    repeat (BufSize + 2) send_byte(8'h55);
    send_byte(8'h33);
    send_byte(hdlc_dfr_pkg::FlagByte);
    frame_payload.delete();
    send_frame(1'b0);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_receiver_backpressure();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    stall_len     = 200;
    stall_req_id++;
    frame_payload.delete();
    repeat (40) frame_payload.push_back(8'($urandom_range(255)));
    send_frame(1'b0);
    set_rx_enable(1'b1);
  endtask

  task automatic test_random_traffic();
    int unsigned target;
    int unsigned pick;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct  = 24;
          sink_idle_pct = 60;
        end
        1: begin
          src_idle_pct  = 60;
          sink_idle_pct = 24;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      set_rx_enable(1'b1);
      target = items_sent + 160;
      while (items_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 72) begin
          random_frame();
        end else if (pick < 87) begin
          // Line noise with many flags and escapes.
          repeat ($urandom_range(1, 6)) send_byte(biased_byte(40));
        end else if (pick < 97) begin
          // A frame cut short, sometimes right after an escape.
          send_byte(hdlc_dfr_pkg::FlagByte);
          repeat ($urandom_range(0, 4)) send_byte(biased_byte(10));
          if ($urandom_range(1)) begin
            send_byte(hdlc_dfr_pkg::EscByte);
          end
          send_byte(hdlc_dfr_pkg::FlagByte);
        end else begin
          set_rx_enable(1'b0);
          repeat ($urandom_range(4, 12)) send_byte(biased_byte(30));
          set_rx_enable(1'b1);
        end
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_disabled_receiver();
    test_directed_frames();
    test_overflow_abort();
    test_receiver_backpressure();
    test_random_traffic();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("hdlc_byte_stuffing_deframer verification clean");
    end else begin
      $display("hdlc_byte_stuffing_deframer verification failed");
    end
    $finish;
  end

  // Guard against a hang.
  initial begin
    #2000000;
    $display("hdlc_byte_stuffing_deframer verification failed");
    $finish;
  end

endmodule

[files.f]
hdl/hdlc_dfr_pkg.sv
hdl/hdlc_dfr_core.sv
hdl/hdlc_byte_stuffing_deframer.sv
hdl/hdlc_dfr_checker.sv
test/testbench.sv
